// ===== rtl/assert_macros.svh =====
// assertion macros shared by the byte ring fifo rtl
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define BRF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define BRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define BRF_ASSERT(lbl, clk, rst_n, prop)
`define BRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/brfm_pkg.sv =====
// shared constants, command codes and transaction types for the byte ring fifo
// no dependencies
`default_nettype none

package brfm_pkg;

	localparam int DEPTH     = 256;
	localparam int MAX_BYTES = 8;
	localparam int BYTE_W    = 8;
	localparam int DATA_W    = MAX_BYTES * BYTE_W;
	localparam int LANE_W    = $clog2(MAX_BYTES);
	localparam int PTR_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int ROWS      = DEPTH / MAX_BYTES;
	localparam int ROW_W     = $clog2(ROWS);
	localparam int LEN_W     = 4;
	localparam int CMD_W     = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [LEN_W-1:0]  length;
		logic [DATA_W-1:0] write_data;
	} cmd_item_t;

	typedef struct packed {
		logic              ok;
		logic [DATA_W-1:0] read_data;
		logic [CNT_W-1:0]  byte_count;
		logic              is_empty;
		logic              is_full;
	} rsp_item_t;

	typedef struct packed {
		logic              ok;
		logic              rd;
		logic [LEN_W-1:0]  len;
		logic [LANE_W-1:0] rot;
		logic [CNT_W-1:0]  byte_count;
		logic              is_empty;
		logic              is_full;
	} res_info_t;

endpackage

`default_nettype wire

// ===== rtl/brfm_lane.sv =====
// one byte lane of the ring store: a small memory with one write and one registered read
// depends on brfm_pkg
`default_nettype none

module brfm_lane
	import brfm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ROW_W-1:0]  waddr,
	input  wire logic [BYTE_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ROW_W-1:0]  raddr,
	output logic      [BYTE_W-1:0] rdata
);

	logic [BYTE_W-1:0] mem_q [ROWS];
	logic [BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/brfm_merge.sv =====
// merging stage: rotates the lane read bytes into stream order and masks unused bytes
// depends on brfm_pkg
`default_nettype none

module brfm_merge
	import brfm_pkg::*;
(
	input  wire logic      [MAX_BYTES-1:0][BYTE_W-1:0] lane_rdata,
	input  wire res_info_t                             info,
	output rsp_item_t                                  rsp
);

	logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;

	always_comb begin
		for (int i = 0; i < MAX_BYTES; i++) begin
			logic [LANE_W-1:0] src;
			src = info.rot + LANE_W'(i);
			if (info.rd && (LEN_W'(i) < info.len)) begin
				bytes[i] = lane_rdata[src];
			end else begin
				bytes[i] = '0;
			end
		end
		rsp.ok         = info.ok;
		rsp.read_data  = bytes;
		rsp.byte_count = info.byte_count;
		rsp.is_empty   = info.is_empty;
		rsp.is_full    = info.is_full;
	end

endmodule

`default_nettype wire

// ===== rtl/byte_ring_fifo_multibyte_top.sv =====
// top level of the multi-byte ring fifo: pointers, access decision, lanes and merge
// depends on brfm_pkg, brfm_lane, brfm_merge and assert_macros.svh
//
// channel  direction  payload       transaction
// cmd      in         cmd_item_t    cmd_valid && cmd_ready
// rsp      out        rsp_item_t    rsp_valid && rsp_ready
// cfg      in         cfg_capacity  cfg_valid && cfg_ready
//
// one access per cycle unless a held result stalls cmd_ready; the result appears in the cycle after the access is taken
// up to eight byte lanes are written, or all eight read, in the same cycle, one row each
// the result register holds while rsp_ready is low; a new access enters as it drains
// reset empties the buffer and sets the capacity to 256; no clearing pass
// a capacity write also empties the buffer
`default_nettype none
`include "assert_macros.svh"

module byte_ring_fifo_multibyte_top
	import brfm_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cmd_valid,
	output logic                  cmd_ready,
	input  wire cmd_item_t        cmd_data,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output rsp_item_t             rsp_data,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CNT_W-1:0] cfg_capacity
);

	logic [CNT_W-1:0] cap_q;
	logic [CNT_W-1:0] held_q;
	logic [PTR_W-1:0] wk_q;
	logic [PTR_W-1:0] rk_q;
	logic             valid_s1;
	res_info_t        res_s1;

	logic             fire;
	logic             cfg_fire;
	logic             len_ok;
	logic             wr_ok;
	logic             rd_ok;
	logic             clr;
	logic [CNT_W-1:0] room;
	logic [CNT_W-1:0] held_next;
	logic [CNT_W-1:0] cap_eff;

	logic [MAX_BYTES-1:0]             lane_we;
	logic [MAX_BYTES-1:0][BYTE_W-1:0] lane_rdata;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign cmd_ready = !valid_s1 || rsp_ready;
	assign fire      = cmd_valid && cmd_ready;
	assign rsp_valid = valid_s1;

	always_comb begin
		len_ok = (cmd_data.length != '0) && (cmd_data.length <= LEN_W'(MAX_BYTES));
		room   = cap_q - held_q;
		wr_ok  = (cmd_data.cmd == CMD_WRITE) && len_ok && (CNT_W'(cmd_data.length) <= room);
		rd_ok  = (cmd_data.cmd == CMD_READ) && len_ok && (CNT_W'(cmd_data.length) <= held_q);
		clr    = (cmd_data.cmd == CMD_CLEAR);
		if (wr_ok) begin
			held_next = held_q + CNT_W'(cmd_data.length);
		end else if (rd_ok) begin
			held_next = held_q - CNT_W'(cmd_data.length);
		end else if (clr) begin
			held_next = '0;
		end else begin
			held_next = held_q;
		end
		if (cfg_capacity == '0) begin
			cap_eff = CNT_W'(1);
		end else if (cfg_capacity > CNT_W'(DEPTH)) begin
			cap_eff = CNT_W'(DEPTH);
		end else begin
			cap_eff = cfg_capacity;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CNT_W'(DEPTH);
			held_q   <= '0;
			wk_q     <= '0;
			rk_q     <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_fire) begin
				cap_q  <= cap_eff;
				held_q <= '0;
				wk_q   <= '0;
				rk_q   <= '0;
			end else if (fire) begin
				held_q <= held_next;
				if (wr_ok) begin
					wk_q <= wk_q + PTR_W'(cmd_data.length);
				end
				if (rd_ok) begin
					rk_q <= rk_q + PTR_W'(cmd_data.length);
				end
				if (clr) begin
					wk_q <= '0;
					rk_q <= '0;
				end
			end
			if (fire) begin
				valid_s1 <= 1'b1;
			end else if (rsp_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s1.ok         <= wr_ok || rd_ok || clr;
			res_s1.rd         <= rd_ok;
			res_s1.len        <= cmd_data.length;
			res_s1.rot        <= rk_q[LANE_W-1:0];
			res_s1.byte_count <= held_next;
			res_s1.is_empty   <= (held_next == '0);
			res_s1.is_full    <= (held_next == cap_q);
		end
	end

	for (genvar j = 0; j < MAX_BYTES; j++) begin : g_lane
		logic [LANE_W-1:0] woff;
		logic [LANE_W-1:0] roff;
		logic [PTR_W-1:0]  wpos;
		logic [PTR_W-1:0]  rpos;

		assign woff       = LANE_W'(j) - wk_q[LANE_W-1:0];
		assign roff       = LANE_W'(j) - rk_q[LANE_W-1:0];
		assign wpos       = wk_q + PTR_W'(woff);
		assign rpos       = rk_q + PTR_W'(roff);
		assign lane_we[j] = fire && !cfg_fire && wr_ok && (LEN_W'(woff) < cmd_data.length);

		brfm_lane u_lane (
			.clk   (clk),
			.we    (lane_we[j]),
			.waddr (wpos[PTR_W-1:LANE_W]),
			.wdata (cmd_data.write_data[woff*BYTE_W +: BYTE_W]),
			.re    (fire && rd_ok),
			.raddr (rpos[PTR_W-1:LANE_W]),
			.rdata (lane_rdata[j])
		);
	end

	brfm_merge u_merge (
		.lane_rdata (lane_rdata),
		.info       (res_s1),
		.rsp        (rsp_data)
	);

	`BRF_ASSERT(a_held_le_cap, clk, arst_n, held_q <= cap_q)
	`BRF_ASSERT(a_ptr_gap, clk, arst_n, held_q[PTR_W-1:0] == PTR_W'(wk_q - rk_q))
	`BRF_ASSERT_NEXT(a_cfg_empties, clk, arst_n, cfg_fire, held_q == '0)
	`BRF_ASSERT_NEXT(a_stall_holds, clk, arst_n, rsp_valid && !rsp_ready, $stable(res_s1))

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for byte_ring_fifo_multibyte_top: directed table, then random accesses
// over several capacities, with a built-in ring buffer predictor; depends on brfm_pkg
`default_nettype none

module tb
	import brfm_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int IDLE_PCT   = 27;
	localparam int HOLD_AT    = 400;
	localparam int HOLD_LEN   = 200;
	localparam int QUIET_LO   = 600;
	localparam int QUIET_HI   = 760;
	localparam int CYCLE_MAX  = 400000;

	typedef struct {
		cmd_item_t item;
		bit        typed;
		rsp_item_t rsp;
	} row_t;

	logic             clk;
	logic             arst_n;
	logic             cmd_valid;
	logic             cmd_ready;
	cmd_item_t        cmd_data;
	logic             rsp_valid;
	logic             rsp_ready;
	rsp_item_t        rsp_data;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_capacity;

	// predictor state
	logic [BYTE_W-1:0] ring_mem [DEPTH];
	int unsigned       wr_ptr;
	int unsigned       rd_ptr;
	int unsigned       held;
	int unsigned       ring_cap;

	rsp_item_t   pending_rsp[$];
	bit          row_typed;
	rsp_item_t   row_rsp;
	int unsigned taken_cnt;
	int unsigned fault_cnt;
	int unsigned cycle_cnt;
	bit          hold_done;
	int unsigned cur_cap;
	row_t        dir_rows[$];

	byte_ring_fifo_multibyte_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd_data     (cmd_data),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.rsp_data     (rsp_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_capacity (cfg_capacity)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int unsigned eff_cap(int unsigned c);
		if (c == 0)
			return 1;
		if (c > DEPTH)
			return DEPTH;
		return c;
	endfunction

	function automatic int unsigned next_slot(int unsigned p, int unsigned cap);
		return (p + 1 >= cap) ? 0 : p + 1;
	endfunction

	function automatic rsp_item_t ring_access(cmd_item_t it);
		int unsigned cap;
		int unsigned n;
		bit          len_good;
		rsp_item_t   r;
		cap = eff_cap(ring_cap);
		n = it.length;
		len_good = (n >= 1) && (n <= MAX_BYTES);
		r = '0;
		case (it.cmd)
			CMD_WRITE: begin
				if (len_good && cap - held >= n) begin
					for (int i = 0; i < n; i++) begin
						ring_mem[wr_ptr] = it.write_data[BYTE_W*i +: BYTE_W];
						wr_ptr = next_slot(wr_ptr, cap);
					end
					held += n;
					r.ok = 1'b1;
				end
			end
			CMD_READ: begin
				if (len_good && held >= n) begin
					for (int i = 0; i < n; i++) begin
						r.read_data[BYTE_W*i +: BYTE_W] = ring_mem[rd_ptr];
						rd_ptr = next_slot(rd_ptr, cap);
					end
					held -= n;
					r.ok = 1'b1;
				end
			end
			CMD_CLEAR: begin
				wr_ptr = 0;
				rd_ptr = 0;
				held = 0;
				r.ok = 1'b1;
			end
			default: ;
		endcase
		r.byte_count = held[CNT_W-1:0];
		r.is_empty = (held == 0);
		r.is_full = (held == cap);
		return r;
	endfunction

	function automatic bit quiet_window();
		return taken_cnt >= QUIET_LO && taken_cnt < QUIET_HI;
	endfunction

	// check results, then record accepted transactions
	always @(posedge clk) begin
		rsp_item_t got;
		rsp_item_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				got = rsp_data;
				if (pending_rsp.size() == 0) begin
					$error("result with no access pending");
					fault_cnt++;
				end else begin
					want = pending_rsp.pop_front();
					if (got.ok !== want.ok) begin
						$error("ok: expected %0d, got %0d", want.ok, got.ok);
						fault_cnt++;
					end
					if (got.read_data !== want.read_data) begin
						$error("read_data: expected %h, got %h", want.read_data, got.read_data);
						fault_cnt++;
					end
					if (got.byte_count !== want.byte_count) begin
						$error("byte_count: expected %0d, got %0d", want.byte_count,
							got.byte_count);
						fault_cnt++;
					end
					if (got.is_empty !== want.is_empty) begin
						$error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
						fault_cnt++;
					end
					if (got.is_full !== want.is_full) begin
						$error("is_full: expected %0d, got %0d", want.is_full, got.is_full);
						fault_cnt++;
					end
				end
			end
			if (cmd_valid && cmd_ready) begin
				want = ring_access(cmd_data);
				if (row_typed)
					want = row_rsp;
				pending_rsp.push_back(want);
				taken_cnt++;
			end
			if (cfg_valid && cfg_ready) begin
				ring_cap = cfg_capacity;
				wr_ptr = 0;
				rd_ptr = 0;
				held = 0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_MAX) begin
			$display("byte_ring_fifo_multibyte_top: mismatch");
			$finish;
		end
	end

	// response side, with one long hold-off
	initial begin
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && taken_cnt >= HOLD_AT) begin
				hold_done = 1'b1;
				rsp_ready <= 1'b0;
				repeat (HOLD_LEN) @(negedge clk);
			end
			rsp_ready <= quiet_window() || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	task automatic drive_access(cmd_item_t it, bit typed, rsp_item_t rsp);
		while (!quiet_window() && $urandom_range(0, 99) < IDLE_PCT) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_data <= it;
		row_typed <= typed;
		row_rsp <= rsp;
		do @(posedge clk); while (!cmd_ready);
		@(negedge clk);
	endtask

	task automatic set_capacity(int unsigned v);
		cmd_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_capacity <= v[CNT_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_cap = v;
	endtask

	function automatic row_t dir_row(logic [CMD_W-1:0] c, int unsigned n,
			logic [DATA_W-1:0] d, bit typed = 1'b0, logic okv = 1'b0,
			logic [DATA_W-1:0] rd = '0, int unsigned cnt = 0, logic em = 1'b0,
			logic fu = 1'b0);
		row_t r;
		r.item.cmd = c;
		r.item.length = n[LEN_W-1:0];
		r.item.write_data = d;
		r.typed = typed;
		r.rsp.ok = okv;
		r.rsp.read_data = rd;
		r.rsp.byte_count = cnt[CNT_W-1:0];
		r.rsp.is_empty = em;
		r.rsp.is_full = fu;
		return r;
	endfunction

	function automatic cmd_item_t rand_access(bit fill, int unsigned cap);
		cmd_item_t   it;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		it.write_data = {$urandom, $urandom};
		it.length = LEN_W'($urandom_range(1, MAX_BYTES));
		if (cap < MAX_BYTES && $urandom_range(0, 1) == 1)
			it.length = LEN_W'($urandom_range(1, cap));
		if (roll < 1) begin
			it.cmd = CMD_CLEAR;
			it.length = LEN_W'($urandom_range(0, 15));
		end else if (roll < 3) begin
			it.cmd = CMD_UNUSED;
			it.length = LEN_W'($urandom_range(0, 15));
		end else begin
			it.cmd = ($urandom_range(0, 99) < (fill ? 75 : 25)) ? CMD_WRITE : CMD_READ;
			if (roll < 7)
				it.length = ($urandom_range(0, 7) == 0) ? '0 : LEN_W'($urandom_range(9, 15));
		end
		return it;
	endfunction

	initial begin
		int unsigned cap_plan[8];
		int unsigned n_items;
		int unsigned chunk;
		bit          fill;
		rsp_item_t   none;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd_data = '0;
		cfg_valid = 1'b0;
		cfg_capacity = '0;
		row_typed = 1'b0;
		row_rsp = '0;
		none = '0;
		ring_cap = DEPTH;
		cur_cap = DEPTH;
		wr_ptr = 0;
		rd_ptr = 0;
		held = 0;
		foreach (ring_mem[k])
			ring_mem[k] = '0;
		cap_plan = '{0, 1, 5, 511, 13, 256, 100, 0};
		cap_plan[7] = $urandom_range(2, 255);

		dir_rows.push_back(dir_row(CMD_READ, 1, '0, 1, 0, '0, 0, 1, 0));
		dir_rows.push_back(dir_row(CMD_WRITE, 0, '1, 1, 0, '0, 0, 1, 0));
		dir_rows.push_back(dir_row(CMD_WRITE, 9, '1, 1, 0, '0, 0, 1, 0));
		dir_rows.push_back(dir_row(CMD_WRITE, 15, '1, 1, 0, '0, 0, 1, 0));
		dir_rows.push_back(dir_row(CMD_READ, 0, '1, 1, 0, '0, 0, 1, 0));
		dir_rows.push_back(dir_row(CMD_UNUSED, 8, '1, 1, 0, '0, 0, 1, 0));
		dir_rows.push_back(dir_row(CMD_CLEAR, 15, '1, 1, 1, '0, 0, 1, 0));
		dir_rows.push_back(dir_row(CMD_WRITE, 8, '1, 1, 1, '0, 8, 0, 0));
		dir_rows.push_back(dir_row(CMD_WRITE, 8, '0, 1, 1, '0, 16, 0, 0));
		dir_rows.push_back(dir_row(CMD_READ, 8, '0, 1, 1, '1, 8, 0, 0));
		dir_rows.push_back(dir_row(CMD_READ, 8, '1, 1, 1, '0, 0, 1, 0));
		dir_rows.push_back(dir_row(CMD_WRITE, 1, 64'h0000_0000_0000_005a));
		dir_rows.push_back(dir_row(CMD_WRITE, 3, 64'ha5a5_0f0f_00c3_96e1));
		dir_rows.push_back(dir_row(CMD_READ, 2, '1));
		dir_rows.push_back(dir_row(CMD_WRITE, 8, 64'h0123_4567_89ab_cdef));
		dir_rows.push_back(dir_row(CMD_READ, 9, '0));
		dir_rows.push_back(dir_row(CMD_READ, 10, '0));
		dir_rows.push_back(dir_row(CMD_READ, 8, '0));
		dir_rows.push_back(dir_row(CMD_UNUSED, 1, 64'h8000_0000_0000_0001));
		dir_rows.push_back(dir_row(CMD_READ, 2, '0));
		dir_rows.push_back(dir_row(CMD_READ, 1, '0));
		dir_rows.push_back(dir_row(CMD_WRITE, 5, 64'hfedc_ba98_7654_3210));
		dir_rows.push_back(dir_row(CMD_CLEAR, 0, '0, 1, 1, '0, 0, 1, 0));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[k])
			drive_access(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].rsp);

		foreach (cap_plan[p]) begin
			set_capacity(cap_plan[p]);
			n_items = (eff_cap(cur_cap) >= 100) ? 210 : 80;
			fill = 1'b1;
			chunk = $urandom_range(20, 100);
			for (int i = 0; i < n_items; i++) begin
				if (chunk == 0) begin
					fill = !fill;
					chunk = $urandom_range(20, 100);
				end
				chunk--;
				drive_access(rand_access(fill, eff_cap(cur_cap)), 1'b0, none);
			end
		end
		cmd_valid <= 1'b0;

		while (pending_rsp.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (fault_cnt == 0)
			$display("byte_ring_fifo_multibyte_top: match");
		else
			$display("byte_ring_fifo_multibyte_top: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
